### sv/rlf_pkg.sv
// Shared types, constants and helpers for the linear RGB fader.
`timescale 1ns / 1ps

package rlf_pkg;

  // LED count and field widths.
  localparam int NUM_LEDS = 8;
  localparam int LED_W    = $clog2(NUM_LEDS);
  localparam int NUM_CH   = 3;
  localparam int COL_W    = 8;
  localparam int STEP_W   = 10;
  localparam int CNT_W    = STEP_W + 1;

  // Colors are kept scaled by 100; the scaled range is 0 to 25500.
  localparam int SCALE     = 100;
  localparam int SCALE_MAX = 255 * SCALE;
  localparam int CUR_W     = 15;
  localparam int INC_W     = CUR_W + 1;

  // Division by 100 as multiplication by a reciprocal; exact below 43699.
  localparam int RECIP    = 5243;
  localparam int RECIP_W  = 13;
  localparam int RECIP_SH = 19;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_SET_CUR  = 2'd0,
    OP_SET_DEST = 2'd1,
    OP_TICK     = 2'd2
  } op_t;

  // Color channel select.
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  // Input transaction.
  typedef struct packed {
    logic [1:0]        operation;
    logic              all_leds;
    logic [LED_W-1:0]  led_index;
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    logic [STEP_W-1:0] fade_steps;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [LED_W-1:0] out_led;
    logic [COL_W-1:0] out_red;
    logic [COL_W-1:0] out_green;
    logic [COL_W-1:0] out_blue;
    logic             last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             jump;
    logic             div_start;
    logic             div_wr;
    logic             tick;
    logic [LED_W-1:0] led;
    chan_t            ch;
  } dp_cmd_t;

endpackage

### sv/rlf_div.sv
// Iterative restoring divider: signed dividend by unsigned nonzero divisor.
`timescale 1ns / 1ps

module rlf_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [rlf_pkg::INC_W-1:0]   dividend,
  input  logic        [rlf_pkg::STEP_W-1:0]  divisor,
  output logic                               done,
  output logic signed [rlf_pkg::INC_W-1:0]   quotient
);

  localparam int CW = $clog2(rlf_pkg::CUR_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [rlf_pkg::STEP_W-1:0]  rem_r;
  logic [rlf_pkg::STEP_W-1:0]  dvs_r;
  logic [rlf_pkg::CUR_W-1:0]   quo_r;
  logic                        neg_r;
  logic [rlf_pkg::STEP_W:0]    trial;
  logic                        fits;
  logic [rlf_pkg::INC_W-1:0]   mag;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial = {rem_r, quo_r[rlf_pkg::CUR_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign mag   = dividend[rlf_pkg::INC_W-1] ? (-dividend) : dividend;

  // Control: one quotient bit per cycle, done pulses after the last bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(rlf_pkg::CUR_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= mag[rlf_pkg::CUR_W-1:0];
      neg_r <= dividend[rlf_pkg::INC_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? rlf_pkg::STEP_W'(trial - {1'b0, dvs_r})
                    : trial[rlf_pkg::STEP_W-1:0];
      quo_r <= {quo_r[rlf_pkg::CUR_W-2:0], fits};
    end
  end

  // Apply the sign: truncation toward zero.
  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

### sv/rlf_ctrl.sv
// Controller state machine: sequences set, fade setup and tick transactions.
`timescale 1ns / 1ps

module rlf_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [1:0]                operation,
  input  logic                      all_leds,
  input  logic [rlf_pkg::LED_W-1:0] led_index,
  input  logic                      div_done,
  output logic                      busy,
  output rlf_pkg::dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_JUMP,
    S_DIV_START,
    S_DIV_WAIT,
    S_TICK
  } state_t;

  localparam logic [rlf_pkg::LED_W-1:0] LAST_LED = rlf_pkg::LED_W'(rlf_pkg::NUM_LEDS - 1);

  state_t                    state_r;
  logic [rlf_pkg::LED_W-1:0] led_r;
  rlf_pkg::chan_t            ch_r;
  logic                      all_r;

  // State, LED counter and channel counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      led_r   <= '0;
      ch_r    <= rlf_pkg::CH_RED;
      all_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            all_r <= all_leds;
            ch_r  <= rlf_pkg::CH_RED;
            case (operation)
              rlf_pkg::OP_SET_CUR: begin
                led_r   <= led_index;
                state_r <= S_JUMP;
              end
              rlf_pkg::OP_SET_DEST: begin
                led_r   <= all_leds ? '0 : led_index;
                state_r <= S_DIV_START;
              end
              rlf_pkg::OP_TICK: begin
                led_r   <= '0;
                state_r <= S_TICK;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_JUMP: begin
          state_r <= S_IDLE;
        end
        S_DIV_START: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (ch_r == rlf_pkg::CH_BLUE) begin
              ch_r <= rlf_pkg::CH_RED;
              if (all_r && (led_r != LAST_LED)) begin
                led_r   <= led_r + 1'b1;
                state_r <= S_DIV_START;
              end else begin
                state_r <= S_IDLE;
              end
            end else begin
              ch_r    <= rlf_pkg::chan_t'(ch_r + 2'd1);
              state_r <= S_DIV_START;
            end
          end
        end
        S_TICK: begin
          if (led_r == LAST_LED) begin
            state_r <= S_IDLE;
          end else begin
            led_r <= led_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Commands decoded from the state.
  assign busy          = (state_r != S_IDLE);
  assign cmd.load      = start && (state_r == S_IDLE);
  assign cmd.jump      = (state_r == S_JUMP);
  assign cmd.div_start = (state_r == S_DIV_START);
  assign cmd.div_wr    = (state_r == S_DIV_WAIT) && div_done;
  assign cmd.tick      = (state_r == S_TICK);
  assign cmd.led       = led_r;
  assign cmd.ch        = ch_r;

endmodule

### sv/rlf_dp.sv
// Datapath: per-LED fade state, increment divider and result pipeline.
`timescale 1ns / 1ps

module rlf_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rlf_pkg::in_item_t  in_data,
  input  rlf_pkg::dp_cmd_t   cmd,
  output logic               div_done,
  output logic               out_valid,
  output rlf_pkg::out_item_t out_data
);

  localparam int NL = rlf_pkg::NUM_LEDS;
  localparam int NC = rlf_pkg::NUM_CH;
  localparam int PW = rlf_pkg::CUR_W + rlf_pkg::RECIP_W;

  // Per-LED state.
  logic        [rlf_pkg::CUR_W-1:0] cur_r [NL][NC];
  logic        [rlf_pkg::COL_W-1:0] tgt_r [NL][NC];
  logic signed [rlf_pkg::INC_W-1:0] inc_r [NL][NC];
  logic        [rlf_pkg::CNT_W-1:0] cnt_r [NL];

  // Latched color and step count of the current transaction.
  logic [rlf_pkg::COL_W-1:0]  col_r [NC];
  logic [rlf_pkg::STEP_W-1:0] steps_r;

  // Result pipeline.
  logic                      s1_v_r;
  logic [rlf_pkg::LED_W-1:0] s1_led_r;
  logic [rlf_pkg::CUR_W-1:0] s1_val_r [NC];
  logic                      s1_last_r;
  logic                      out_valid_r;
  rlf_pkg::out_item_t        out_data_r;

  logic [rlf_pkg::CNT_W-1:0]         sel_cnt;
  logic                              tick_act;
  logic [rlf_pkg::CNT_W-1:0]         cnt_nxt;
  logic [rlf_pkg::CUR_W-1:0]         cur_nxt [NC];
  logic                              later_act;
  logic signed [rlf_pkg::INC_W-1:0]  diff;
  logic signed [rlf_pkg::INC_W-1:0]  quotient;
  logic signed [rlf_pkg::INC_W:0]    sum [NC];

  // Scale a color component by 100.
  function automatic logic [rlf_pkg::CUR_W-1:0] scale_up(input logic [rlf_pkg::COL_W-1:0] c);
    return rlf_pkg::CUR_W'(c) * rlf_pkg::CUR_W'(rlf_pkg::SCALE);
  endfunction

  // Divide a scaled value by 100 through the reciprocal.
  function automatic logic [rlf_pkg::COL_W-1:0] scale_down(input logic [rlf_pkg::CUR_W-1:0] v);
    logic [PW-1:0] prod;
    prod = PW'(v) * PW'(rlf_pkg::RECIP);
    return prod[rlf_pkg::RECIP_SH +: rlf_pkg::COL_W];
  endfunction

  // Difference to the target for the channel being set up.
  assign diff = $signed({1'b0, scale_up(col_r[cmd.ch])})
              - $signed({1'b0, cur_r[cmd.led][cmd.ch]});

  rlf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (diff),
    .divisor  (steps_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Tick arithmetic for the LED under the walk: step with clamp, or snap.
  assign sel_cnt  = cnt_r[cmd.led];
  assign tick_act = (sel_cnt != '0);
  assign cnt_nxt  = sel_cnt - 1'b1;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      sum[c] = $signed({2'b00, cur_r[cmd.led][c]})
             + $signed({inc_r[cmd.led][c][rlf_pkg::INC_W-1], inc_r[cmd.led][c]});
      if (cnt_nxt == '0) begin
        cur_nxt[c] = scale_up(tgt_r[cmd.led][c]);
      end else if (sum[c] < 0) begin
        cur_nxt[c] = '0;
      end else if (sum[c] > (rlf_pkg::INC_W+1)'(rlf_pkg::SCALE_MAX)) begin
        cur_nxt[c] = rlf_pkg::CUR_W'(rlf_pkg::SCALE_MAX);
      end else begin
        cur_nxt[c] = sum[c][rlf_pkg::CUR_W-1:0];
      end
    end
  end

  // A result is the last of its tick when no higher LED is still fading.
  always_comb begin
    later_act = 1'b0;
    for (int i = 0; i < NL; i++) begin
      if ((rlf_pkg::LED_W'(i) > cmd.led) && (cnt_r[i] != '0)) begin
        later_act = 1'b1;
      end
    end
  end

  // State updates for set current, fade setup and tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NL; i++) begin
        cnt_r[i] <= '0;
        for (int c = 0; c < NC; c++) begin
          cur_r[i][c] <= '0;
          tgt_r[i][c] <= '0;
          inc_r[i][c] <= '0;
        end
      end
    end else begin
      if (cmd.jump) begin
        cnt_r[cmd.led] <= '0;
        for (int c = 0; c < NC; c++) begin
          cur_r[cmd.led][c] <= scale_up(col_r[c]);
          tgt_r[cmd.led][c] <= col_r[c];
        end
      end
      if (cmd.div_wr) begin
        inc_r[cmd.led][cmd.ch] <= quotient;
        tgt_r[cmd.led][cmd.ch] <= col_r[cmd.ch];
        if (cmd.ch == rlf_pkg::CH_BLUE) begin
          cnt_r[cmd.led] <= {1'b0, steps_r} + 1'b1;
        end
      end
      if (cmd.tick && tick_act) begin
        cnt_r[cmd.led] <= cnt_nxt;
        for (int c = 0; c < NC; c++) begin
          cur_r[cmd.led][c] <= cur_nxt[c];
        end
      end
    end
  end

  // Latch the transaction's color and step count; zero steps count as one.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r[0] <= in_data.red;
      col_r[1] <= in_data.green;
      col_r[2] <= in_data.blue;
      steps_r  <= (in_data.fade_steps == '0) ? rlf_pkg::STEP_W'(1) : in_data.fade_steps;
    end
  end

  // Result valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= cmd.tick && tick_act;
      out_valid_r <= s1_v_r;
    end
  end

  // Result payload: new scaled values, then divided by 100.
  always_ff @(posedge clk) begin
    s1_led_r  <= cmd.led;
    s1_last_r <= !later_act;
    for (int c = 0; c < NC; c++) begin
      s1_val_r[c] <= cur_nxt[c];
    end
    out_data_r.out_led   <= s1_led_r;
    out_data_r.out_red   <= scale_down(s1_val_r[0]);
    out_data_r.out_green <= scale_down(s1_val_r[1]);
    out_data_r.out_blue  <= scale_down(s1_val_r[2]);
    out_data_r.last      <= s1_last_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // Every result strobe follows a tick step that found an active LED.
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s1_v_r))
    else $error("result strobe without a preceding tick step");

  // Scaled colors stay within the clamp range.
  a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_val_r[0] <= rlf_pkg::CUR_W'(rlf_pkg::SCALE_MAX))
            && (s1_val_r[1] <= rlf_pkg::CUR_W'(rlf_pkg::SCALE_MAX))
            && (s1_val_r[2] <= rlf_pkg::CUR_W'(rlf_pkg::SCALE_MAX)))
    else $error("scaled color out of range");

  // Increments are written only with a finished quotient.
  a_div_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_wr |-> div_done)
    else $error("increment written before division finished");

  // An idle LED produces no result.
  a_idle_led: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick && !tick_act) |=> !s1_v_r)
    else $error("result produced for an idle LED");
`endif

endmodule

### sv/rgb_led_linear_fader_core.sv
// A set current transaction keeps busy high for a single cycle.
// A set destination runs each channel in turn through the shared divider,
// and then each LED in turn when applied to every LED.
// A tick walks one LED per cycle; each result passes through the s1 stage
// and the output register, and results cannot be stalled.
// Reset (synchronous, rst_n low) clears every LED to black and idle.
`timescale 1ns / 1ps

module rgb_led_linear_fader_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rlf_pkg::in_item_t  in_data,
  output logic               out_valid,
  output rlf_pkg::out_item_t out_data
);

  rlf_pkg::dp_cmd_t cmd;
  logic             div_done;

  // Sequencer for the three transaction kinds.
  rlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_data.operation),
    .all_leds  (in_data.all_leds),
    .led_index (in_data.led_index),
    .div_done  (div_done),
    .busy      (busy),
    .cmd       (cmd)
  );

  // LED state, divider and result pipeline.
  rlf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .div_done  (div_done),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
